[rtl/assert_macros.svh]
// Assertion macros shared by the vector normalizer RTL.
// Checks use clk_i and rst_ni of the including module; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define VN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define VN_ASSERT_NEVER(lbl, cond, msg) \
  `VN_ASSERT(lbl, !(cond), msg)

`else

`define VN_ASSERT(lbl, prop, msg)
`define VN_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[rtl/vn_pkg.sv]
// Shared widths, opcodes and handshake structs of the vector normalizer.
// No dependencies; used by vn_alu and vector_normalizer_core.
package vn_pkg;

  localparam int VN_MAX_LEN   = 64;
  localparam int VN_ADDR_W    = (VN_MAX_LEN > 1) ? $clog2(VN_MAX_LEN) : 1;
  localparam int VN_CNT_W     = $clog2(VN_MAX_LEN + 1);
  localparam int VN_ELEM_W    = 16;
  localparam int VN_SUM_W     = 37;
  localparam int VN_ROOT_W    = (VN_SUM_W + 1) / 2;
  localparam int VN_SRC_W     = 2 * VN_ROOT_W;
  localparam int VN_REM_W     = VN_ROOT_W + 3;
  localparam int VN_FRAC_SH   = 14;
  localparam int VN_DIV_STEPS = VN_FRAC_SH + 1;
  localparam int VN_STEP_W    = $clog2(VN_ROOT_W);
  localparam int VN_UNIT_MAX  = 1 << VN_FRAC_SH;

  typedef enum logic {
    VN_OP_SQRT,
    VN_OP_DIV
  } vn_op_e;

  typedef struct packed {
    logic   start;
    vn_op_e op;
  } vn_alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } vn_alu_sts_t;

endpackage

[rtl/vn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/vn_alu.sv]
// Shared compare-subtract-shift unit: floor square root and restoring division.
// Depends on vn_pkg for widths, opcodes and command/status structs.
module vn_alu (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vn_pkg::vn_alu_cmd_t              cmd_i,
  input  logic [vn_pkg::VN_SUM_W-1:0]      radicand_i,
  input  logic [vn_pkg::VN_ROOT_W-1:0]     divisor_i,
  input  logic [vn_pkg::VN_ELEM_W-1:0]     dividend_i,
  output vn_pkg::vn_alu_sts_t              sts_o,
  output logic [vn_pkg::VN_ROOT_W-1:0]     result_o
);

  localparam int RemW  = vn_pkg::VN_REM_W;
  localparam int RootW = vn_pkg::VN_ROOT_W;
  localparam int SrcW  = vn_pkg::VN_SRC_W;
  localparam int StepW = vn_pkg::VN_STEP_W;
  localparam int ElemW = vn_pkg::VN_ELEM_W;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  vn_pkg::vn_op_e      op_q, op_d;
  logic [StepW-1:0]    cnt_q, cnt_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RootW-1:0]    res_q, res_d;
  logic [SrcW-1:0]     src_q, src_d;
  logic [RootW-1:0]    div_q, div_d;

  logic [RemW-1:0]     acc;
  logic [RemW-1:0]     trial;
  logic [RemW-1:0]     diff;
  logic [SrcW-1:0]     src_shift;
  logic                ge;

  // Form the trial operand: two radicand bits per root step, one dividend bit per quotient step
  always_comb begin
    if (op_q == vn_pkg::VN_OP_SQRT) begin
      acc       = {rem_q[RemW-3:0], src_q[SrcW-1 -: 2]};
      trial     = {1'b0, res_q, 2'b01};
      src_shift = {src_q[SrcW-3:0], 2'b00};
    end else begin
      acc       = {rem_q[RemW-2:0], src_q[SrcW-1]};
      trial     = {{(RemW - RootW){1'b0}}, div_q};
      src_shift = {src_q[SrcW-2:0], 1'b0};
    end
    ge   = (acc >= trial);
    diff = acc - trial;
  end

  // Load on start, then one restoring step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    res_d  = res_q;
    src_d  = src_q;
    div_d  = div_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      res_d  = '0;
      div_d  = divisor_i;
      if (cmd_i.op == vn_pkg::VN_OP_SQRT) begin
        cnt_d = StepW'(RootW - 1);
        rem_d = '0;
        src_d = SrcW'(radicand_i);
      end else begin
        cnt_d = StepW'(vn_pkg::VN_DIV_STEPS - 1);
        rem_d = RemW'(dividend_i[ElemW-1:1]);
        src_d = {dividend_i[0], {(SrcW - 1){1'b0}}};
      end
    end else if (busy_q) begin
      rem_d = ge ? diff : acc;
      res_d = {res_q[RootW-2:0], ge};
      src_d = src_shift;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - StepW'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    res_q <= res_d;
    src_q <= src_d;
    div_q <= div_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = res_q;

endmodule

[rtl/vector_normalizer_core.sv]
// Vector L2 normalizer: takes Q4.12 elements one beat per cycle until tlast, then
// emits each element divided by the Euclidean norm as Q1.14 (truncated toward zero).
// An element beat is taken every cycle while a vector is collected. After the last
// beat the input stalls: the floor square root of the 37-bit sum of squares is
// taken, then each result is made in turn (one store read, one load, a 15-step
// division and its done strobe, one output beat held until taken), and the input
// stays closed until the last result is taken. The single compare-subtract-shift
// unit runs the root and every division. A zero norm skips the divisions. Up to 64
// elements are kept; further beats are dropped and flagged in tuser on every
// result of that vector.
// Depends on vn_pkg, vn_ram, vn_alu and assert_macros.svh.
`include "assert_macros.svh"

module vector_normalizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Element stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] element
  input  logic        s_axis_tlast_i,   // is_last
  // Normalized stream out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] unit_element
  output logic        m_axis_tlast_o,   // last_out
  output logic [1:0]  m_axis_tuser_o    // [0] zero_norm, [1] overflow
);

  localparam int AddrW = vn_pkg::VN_ADDR_W;
  localparam int CntW  = vn_pkg::VN_CNT_W;
  localparam int ElemW = vn_pkg::VN_ELEM_W;
  localparam int SumW  = vn_pkg::VN_SUM_W;
  localparam int RootW = vn_pkg::VN_ROOT_W;

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_ROOT    = 3'd1;
  localparam logic [2:0] ST_ROOTW   = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_LOAD    = 3'd4;
  localparam logic [2:0] ST_DIVW    = 3'd5;
  localparam logic [2:0] ST_EMIT    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               dropped_q, dropped_d;
  logic [RootW-1:0]   norm_q, norm_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic [ElemW-1:0]   elem_q, elem_d;
  logic [ElemW-1:0]   unit_q, unit_d;
  logic               last_q, last_d;
  logic               zero_q, zero_d;
  logic               ovf_q, ovf_d;

  logic               in_beat;
  logic               room;
  logic [ElemW-1:0]   in_mag;
  logic [2*ElemW-1:0] in_sq;
  logic [ElemW-1:0]   rd_data;
  logic [ElemW-1:0]   rd_mag;
  logic               rd_en;
  logic [RootW-1:0]   alu_res;
  logic [RootW-1:0]   quot;
  vn_pkg::vn_alu_cmd_t alu_cmd;
  vn_pkg::vn_alu_sts_t alu_sts;

  // Input beat and square of its magnitude
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;
  assign room    = (count_q < CntW'(vn_pkg::VN_MAX_LEN));
  assign in_mag  = s_axis_tdata_i[ElemW-1] ? (~s_axis_tdata_i + ElemW'(1)) : s_axis_tdata_i;
  assign in_sq   = in_mag * in_mag;
  assign rd_mag  = rd_data[ElemW-1] ? (~rd_data + ElemW'(1)) : rd_data;

  // Clamp the quotient to full scale
  assign quot = (alu_res > RootW'(vn_pkg::VN_UNIT_MAX)) ? RootW'(vn_pkg::VN_UNIT_MAX) : alu_res;

  vn_ram #(
    .WIDTH (ElemW),
    .DEPTH (vn_pkg::VN_MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_beat && room),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  vn_alu u_alu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (alu_cmd),
    .radicand_i (sum_q),
    .divisor_i  (norm_q),
    .dividend_i (rd_mag),
    .sts_o      (alu_sts),
    .result_o   (alu_res)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    dropped_d   = dropped_q;
    norm_d      = norm_q;
    idx_d       = idx_q;
    elem_d      = elem_q;
    unit_d      = unit_q;
    last_d      = last_q;
    zero_d      = zero_q;
    ovf_d       = ovf_q;
    rd_en       = 1'b0;
    alu_cmd     = '{start: 1'b0, op: vn_pkg::VN_OP_SQRT};
    unique case (state_q)
      ST_COLLECT: begin
        // Store the element and accumulate, or drop it when full
        if (in_beat) begin
          if (room) begin
            count_d = count_q + CntW'(1);
            sum_d   = sum_q + SumW'(in_sq);
          end else begin
            dropped_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        alu_cmd = '{start: 1'b1, op: vn_pkg::VN_OP_SQRT};
        state_d = ST_ROOTW;
      end
      ST_ROOTW: begin
        if (alu_sts.done) begin
          norm_d  = alu_res;
          idx_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // Latch the element and its flags, then divide unless the norm is zero
        elem_d = rd_data;
        last_d = ((CntW'(idx_q) + CntW'(1)) == count_q);
        zero_d = (norm_q == '0);
        ovf_d  = dropped_q;
        if (norm_q == '0) begin
          unit_d  = '0;
          state_d = ST_EMIT;
        end else begin
          alu_cmd = '{start: 1'b1, op: vn_pkg::VN_OP_DIV};
          state_d = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (alu_sts.done) begin
          unit_d  = elem_q[ElemW-1] ? (~quot[ElemW-1:0] + ElemW'(1)) : quot[ElemW-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold the result until taken; clear the vector after its last beat
        if (m_axis_tready_i) begin
          if (last_q) begin
            count_d   = '0;
            sum_d     = '0;
            dropped_d = 1'b0;
            state_d   = ST_COLLECT;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COLLECT;
      count_q   <= '0;
      sum_q     <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      dropped_q <= dropped_d;
    end
  end

  // Datapath and output registers
  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
    idx_q  <= idx_d;
    elem_q <= elem_d;
    unit_q <= unit_d;
    last_q <= last_d;
    zero_q <= zero_d;
    ovf_q  <= ovf_d;
  end

  assign s_axis_tready_o = (state_q == ST_COLLECT);
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign m_axis_tdata_o  = unit_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = {ovf_q, zero_q};

  // Checks
  `VN_ASSERT_NEVER(a_in_out_excl, s_axis_tready_o && m_axis_tvalid_o, "input and output both open")
  `VN_ASSERT_NEVER(a_count_bound, count_q > CntW'(vn_pkg::VN_MAX_LEN), "element count past capacity")
  `VN_ASSERT_NEVER(a_start_busy, alu_cmd.start && alu_sts.busy, "unit started while busy")
  `VN_ASSERT(a_last_clears, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> (count_q == '0) && s_axis_tready_o, "vector not cleared after last beat")

endmodule
